FILE: rtl/core/m2x2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2x2_pkg
// Opcodes, port width and the request/result payload types of the 2x2 unit.
// ----------------------------------------------------------------------------
package m2x2_pkg;

  localparam int PORT_W = 32;

  typedef enum logic [3:0] {
    OP_INV   = 4'd0,
    OP_MUL   = 4'd1,
    OP_MATV  = 4'd2,
    OP_VMAT  = 4'd3,
    OP_TRANS = 4'd4,
    OP_ADD   = 4'd5,
    OP_SUB   = 4'd6,
    OP_EYE   = 4'd7,
    OP_GAIN  = 4'd8
  } op_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [PORT_W-1:0] a_00;
    logic [PORT_W-1:0] a_01;
    logic [PORT_W-1:0] a_10;
    logic [PORT_W-1:0] a_11;
    logic [PORT_W-1:0] b_00;
    logic [PORT_W-1:0] b_01;
    logic [PORT_W-1:0] b_10;
    logic [PORT_W-1:0] b_11;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] r_00;
    logic [PORT_W-1:0] r_01;
    logic [PORT_W-1:0] r_10;
    logic [PORT_W-1:0] r_11;
    logic              singular;
  } res_t;

endpackage

FILE: rtl/core/m2x2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2x2_req_if / m2x2_res_if
// Valid/ready channels carrying a request and a result.
// ----------------------------------------------------------------------------
interface m2x2_req_if;
  import m2x2_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m2x2_res_if;
  import m2x2_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/m2x2_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2x2_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module m2x2_queue
  import m2x2_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_data
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/m2x2_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2x2_front
// Input register stage; folds unused opcodes to a request with zero operands.
// ----------------------------------------------------------------------------
module m2x2_front
  import m2x2_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_data
);

  logic vld;
  req_t hold;
  req_t cls;

  always_comb begin
    cls = in_data;
    // An unused opcode becomes an add of zeros, which yields an all-zero result.
    if (in_data.op > OP_GAIN) begin
      cls      = '0;
      cls.op   = OP_ADD;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= cls;
    end
  end

endmodule

FILE: rtl/core/m2x2_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2x2_back
// Execution pipeline: multiplies, determinant, pipelined reciprocal, scaling.
// ----------------------------------------------------------------------------
module m2x2_back
  import m2x2_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam int W     = DATA_WIDTH;
  localparam int NW    = 2 * FRAC_BITS + 2;
  localparam int DEPTH = NW + 5;
  localparam int LAST  = DEPTH - 1;

  typedef logic signed [W-1:0] val_t;

  function automatic val_t fin(input logic [PORT_W-1:0] x);
    logic signed [PORT_W-1:0] s;
    logic signed [W+PORT_W-1:0] e;
    begin
      s = x;
      e = W'(s) ;
      fin = e[W-1:0];
    end
  endfunction

  function automatic val_t mulq(input val_t a, input val_t b);
    logic signed [2*W-1:0] p;
    begin
      p = (2*W)'(a) * (2*W)'(b);
      p = p >>> FRAC_BITS;
      mulq = p[W-1:0];
    end
  endfunction

  function automatic val_t sat_sign(input val_t x);
    begin
      if (x == '0) begin
        sat_sign = '0;
      end else if (x[W-1]) begin
        sat_sign = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_sign = {1'b0, {(W-1){1'b1}}};
      end
    end
  endfunction

  typedef struct packed {
    logic [3:0] op;
    val_t [3:0] a;
    val_t [3:0] b;
    val_t [3:0] p;
    val_t [3:0] q;
    val_t       det;
    logic       neg;
    logic [NW-1:0] quo;
    logic [W:0]    rem;
    logic [W-1:0]  dmag;
    val_t [3:0] r;
    logic       sing;
  } slot_t;

  slot_t   st   [DEPTH];
  logic    vld  [DEPTH];
  logic    adv;
  slot_t   s0;

  assign adv       = !vld[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAST];

  always_comb begin
    s0    = '0;
    s0.op = in_data.op;
    s0.a[0] = fin(in_data.a_00);
    s0.a[1] = fin(in_data.a_01);
    s0.a[2] = fin(in_data.a_10);
    s0.a[3] = fin(in_data.a_11);
    s0.b[0] = fin(in_data.b_00);
    s0.b[1] = fin(in_data.b_01);
    s0.b[2] = fin(in_data.b_10);
    s0.b[3] = fin(in_data.b_11);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 0: up to eight products, operand choice by opcode.
  always_ff @(posedge clk) begin
    slot_t c;
    if (adv) begin
      c = s0;
      case (c.op)
        OP_INV: begin
          c.p[0] = mulq(s0.a[0], s0.a[3]);
          c.q[0] = mulq(s0.a[1], s0.a[2]);
        end
        OP_MUL: begin
          c.p[0] = mulq(s0.a[0], s0.b[0]);
          c.q[0] = mulq(s0.a[1], s0.b[2]);
          c.p[1] = mulq(s0.a[0], s0.b[1]);
          c.q[1] = mulq(s0.a[1], s0.b[3]);
          c.p[2] = mulq(s0.a[2], s0.b[0]);
          c.q[2] = mulq(s0.a[3], s0.b[2]);
          c.p[3] = mulq(s0.a[2], s0.b[1]);
          c.q[3] = mulq(s0.a[3], s0.b[3]);
        end
        OP_MATV: begin
          c.p[0] = mulq(s0.a[0], s0.b[0]);
          c.q[0] = mulq(s0.a[1], s0.b[1]);
          c.p[1] = mulq(s0.a[2], s0.b[0]);
          c.q[1] = mulq(s0.a[3], s0.b[1]);
        end
        OP_VMAT: begin
          c.p[0] = mulq(s0.b[0], s0.a[0]);
          c.q[0] = mulq(s0.b[1], s0.a[2]);
          c.p[1] = mulq(s0.b[0], s0.a[1]);
          c.q[1] = mulq(s0.b[1], s0.a[3]);
        end
        OP_GAIN: begin
          for (int i = 0; i < 4; i++) begin
            c.p[i] = mulq(s0.a[i], s0.b[0]);
          end
        end
        default: begin
        end
      endcase
      st[0] <= c;
    end
  end

  // Stage 1: sums, determinant, simple ops, divider setup.
  always_ff @(posedge clk) begin
    slot_t c;
    val_t  d;
    logic [W-1:0] mag;
    if (adv) begin
      c = st[0];
      d = c.p[0] - c.q[0];
      mag = d[W-1] ? -d : d;
      c.det  = d;
      c.neg  = d[W-1];
      c.dmag = mag;
      c.quo  = {1'b0, 1'b1, {(2*FRAC_BITS){1'b0}}};
      c.rem  = '0;
      c.sing = 1'b0;
      case (c.op)
        OP_MUL, OP_MATV, OP_VMAT: begin
          for (int i = 0; i < 4; i++) begin
            c.r[i] = c.p[i] + c.q[i];
          end
          if (c.op != OP_MUL) begin
            c.r[2] = '0;
            c.r[3] = '0;
          end
        end
        OP_GAIN: c.r = c.p;
        OP_TRANS: begin
          c.r[0] = c.a[0]; c.r[1] = c.a[2]; c.r[2] = c.a[1]; c.r[3] = c.a[3];
        end
        OP_ADD: begin
          for (int i = 0; i < 4; i++) begin
            c.r[i] = c.a[i] + c.b[i];
          end
        end
        OP_SUB: begin
          for (int i = 0; i < 4; i++) begin
            c.r[i] = c.a[i] - c.b[i];
          end
        end
        OP_EYE: begin
          c.r[0] = c.a[0] + c.b[0]; c.r[1] = c.a[1];
          c.r[2] = c.a[2];          c.r[3] = c.a[3] + c.b[0];
        end
        default: begin
          // Inverse: the adjugate waits in r.
          c.r[0] = c.a[3]; c.r[1] = -c.a[1];
          c.r[2] = -c.a[2]; c.r[3] = c.a[0];
          c.sing = (d == '0);
        end
      endcase
      st[1] <= c;
    end
  end

  // Restoring divider of 2^(2F) by |det|, one quotient bit per stage.
  for (genvar k = 0; k < NW; k++) begin : g_div
    always_ff @(posedge clk) begin
      slot_t c;
      logic [W+1:0] t;
      if (adv) begin
        c = st[k+1];
        t = {c.rem, c.quo[NW-1]};
        c.quo = {c.quo[NW-2:0], 1'b0};
        if (t >= {2'b0, c.dmag}) begin
          t = t - {2'b0, c.dmag};
          c.quo[0] = 1'b1;
        end
        c.rem = t[W:0];
        st[k+2] <= c;
      end
    end
  end

  // Saturate the signed reciprocal into the gain, kept in p[0].
  always_ff @(posedge clk) begin
    slot_t c;
    logic [NW:0] g;
    if (adv) begin
      c = st[NW+1];
      g = c.neg ? -{1'b0, c.quo} : {1'b0, c.quo};
      if (!c.neg && (c.quo > NW'({(W-1){1'b1}}))) begin
        c.p[0] = {1'b0, {(W-1){1'b1}}};
      end else if (c.neg && (c.quo > NW'({1'b1, {(W-1){1'b0}}}))) begin
        c.p[0] = {1'b1, {(W-1){1'b0}}};
      end else begin
        c.p[0] = g[W-1:0];
      end
      st[NW+2] <= c;
    end
  end

  always_ff @(posedge clk) begin
    slot_t c;
    if (adv) begin
      c = st[NW+2];
      if (c.op == OP_INV) begin
        for (int i = 0; i < 4; i++) begin
          c.q[i] = c.sing ? sat_sign(c.r[i]) : mulq(c.p[0], c.r[i]);
        end
        c.r = c.q;
      end
      st[NW+3] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[LAST] <= st[NW+3];
    end
  end

  assign out_data.r_00     = PORT_W'(st[LAST].r[0]);
  assign out_data.r_01     = PORT_W'(st[LAST].r[1]);
  assign out_data.r_10     = PORT_W'(st[LAST].r[2]);
  assign out_data.r_11     = PORT_W'(st[LAST].r[3]);
  assign out_data.singular = st[LAST].sing;

endmodule

FILE: rtl/core/matrix2x2_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix2x2_fixed_point_alu
// 2x2 signed fixed-point matrix unit with a decoupled front and back.
// ----------------------------------------------------------------------------
// One request enters and one result leaves per cycle while the result port is
// not stalled. Every request takes the full back pipeline, 2*FRAC_BITS+7 stages
// plus the front register and the queue; its length is set by the restoring
// reciprocal divider, which retires one quotient bit per stage. The two-entry
// queue lets the front take requests while the result port stalls, until full.
module matrix2x2_fixed_point_alu
  import m2x2_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input logic  clk,
  input logic  rst,
  m2x2_req_if.sink   req,
  m2x2_res_if.source res
);

  logic f_valid, f_ready, q_valid, q_ready;
  req_t f_data, q_data;

  m2x2_front u_front (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  m2x2_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  m2x2_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
  );

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.singular |->
      ((res.data.r_00 == '0) || (res.data.r_00 == 32'h7fffffff) ||
       (res.data.r_00 == 32'h80000000)))
    else $error("singular result is not saturated");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result changed while stalled");

endmodule
